@@ rtl/cardinality_constraint_propagator_macros.svh @@
// Assertion macros shared by the checker of the constraint propagator.
`ifndef CARDINALITY_CONSTRAINT_PROPAGATOR_MACROS_SVH
`define CARDINALITY_CONSTRAINT_PROPAGATOR_MACROS_SVH

// Concurrent assertion clocked on the rising edge, off while reset is high.
`define CCP_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check on the block's clock and reset.
`define CCP_ASSERT(label, prop, msg) \
   `CCP_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ rtl/ccp_pkg.sv @@
// Package: types, codes and entry layout of the cardinality constraint propagator.
package ccp_pkg;

   // Table depth default
   localparam int CCP_ENTRIES = 1024;

   // Function codes
   localparam logic [1:0] FUNC_LOAD      = 2'd0;
   localparam logic [1:0] FUNC_PROPAGATE = 2'd1;
   localparam logic [1:0] FUNC_REVERSE   = 2'd2;

   // Event kinds
   localparam logic [1:0] EVT_TRUE_COUNT = 2'd0;
   localparam logic [1:0] EVT_NON_COUNT  = 2'd1;

   // Output values
   localparam logic [1:0] OUT_TRUE  = 2'd1;
   localparam logic [1:0] OUT_FALSE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_UNDECIDED  = 2'd0;
   localparam logic [1:0] ST_CONSISTENT = 2'd1;
   localparam logic [1:0] ST_CONFLICT   = 2'd2;

   // Action codes
   localparam logic [2:0] ACT_NONE        = 3'd0;
   localparam logic [2:0] ACT_OUT_TRUE    = 3'd1;
   localparam logic [2:0] ACT_OUT_FALSE   = 3'd2;
   localparam logic [2:0] ACT_FORCE_TRUE  = 3'd3;
   localparam logic [2:0] ACT_FORCE_FALSE = 3'd4;

   typedef enum logic {
      CCP_IDLE,
      CCP_RMW
   } ccp_state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  entry_index;
      logic [1:0]  event_kind;
      logic [1:0]  out_value;
      logic [15:0] decision_level;
      logic [7:0]  load_cutoff;
      logic [7:0]  load_true_count;
      logic [7:0]  load_undef_count;
      logic        load_no_output;
   } ccp_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  action;
      logic [15:0] assign_level;
   } ccp_rsp_type;

   typedef struct packed {
      logic       no_output;
      logic [7:0] cutoff;
      logic [7:0] undef_count;
      logic [7:0] true_count;
   } ccp_entry_type;

endpackage

@@ rtl/ccp_table.sv @@
// Constraint table: single-port-write, registered-read synchronous memory.
module ccp_table #(
   parameter int ENTRIES = ccp_pkg::CCP_ENTRIES,
   parameter int AW      = $clog2(ccp_pkg::CCP_ENTRIES)
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output ccp_pkg::ccp_entry_type rd_data,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  ccp_pkg::ccp_entry_type wr_data
);
   import ccp_pkg::*;

   ccp_entry_type mem_ff [ENTRIES];
   ccp_entry_type rd_data_ff;

   // Write back the modified entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ccp_eval.sv @@
// Count update and classification of one entry against the output value.
module ccp_eval (
   input  ccp_pkg::ccp_req_type   req,
   input  ccp_pkg::ccp_entry_type cur,
   output ccp_pkg::ccp_entry_type nxt,
   output logic                   upd_en,
   output ccp_pkg::ccp_rsp_type   rsp
);
   import ccp_pkg::*;

   logic [7:0] t_inc, t_dec, u_inc, u_dec;
   logic [8:0] sum;
   logic       noout, otrue, ofalse, prop;
   logic [1:0] status;
   logic [2:0] action;

   // Saturating steps of the counts
   assign t_inc = (cur.true_count == 8'hFF) ? cur.true_count : cur.true_count + 8'd1;
   assign t_dec = (cur.true_count == 8'h00) ? cur.true_count : cur.true_count - 8'd1;
   assign u_inc = (cur.undef_count == 8'hFF) ? cur.undef_count : cur.undef_count + 8'd1;
   assign u_dec = (cur.undef_count == 8'h00) ? cur.undef_count : cur.undef_count - 8'd1;

   // Build the entry to write back
   always_comb begin
      nxt    = cur;
      upd_en = 1'b1;
      prop   = 1'b0;
      unique case (req.func)
         FUNC_LOAD: begin
            nxt.no_output   = req.load_no_output;
            nxt.cutoff      = req.load_cutoff;
            nxt.true_count  = req.load_true_count;
            nxt.undef_count = req.load_undef_count;
         end
         FUNC_PROPAGATE: begin
            prop = 1'b1;
            if (req.event_kind == EVT_TRUE_COUNT) begin
               nxt.true_count  = t_inc;
               nxt.undef_count = u_dec;
            end else if (req.event_kind == EVT_NON_COUNT) begin
               nxt.undef_count = u_dec;
            end
         end
         FUNC_REVERSE: begin
            if (req.event_kind == EVT_TRUE_COUNT) begin
               nxt.true_count  = t_dec;
               nxt.undef_count = u_inc;
            end else if (req.event_kind == EVT_NON_COUNT) begin
               nxt.undef_count = u_inc;
            end
         end
         default: begin
            upd_en = 1'b0;
         end
      endcase
   end

   // Classify the updated entry
   assign sum    = {1'b0, nxt.true_count} + {1'b0, nxt.undef_count};
   assign noout  = nxt.no_output;
   assign otrue  = (req.out_value == OUT_TRUE);
   assign ofalse = (req.out_value == OUT_FALSE);

   always_comb begin
      status = ST_UNDECIDED;
      action = ACT_NONE;
      if (sum < {1'b0, nxt.cutoff}) begin
         if (noout || otrue) begin
            status = ST_CONFLICT;
         end else begin
            status = ST_CONSISTENT;
            if (!ofalse) begin
               action = ACT_OUT_FALSE;
            end
         end
      end else if (nxt.true_count >= nxt.cutoff) begin
         if (noout || otrue) begin
            status = ST_CONSISTENT;
         end else if (ofalse) begin
            status = ST_CONFLICT;
         end else begin
            status = ST_CONSISTENT;
            action = ACT_OUT_TRUE;
         end
      end else if ((noout || otrue) && sum == {1'b0, nxt.cutoff}) begin
         status = ST_CONSISTENT;
         action = ACT_FORCE_TRUE;
      end else if (!noout && ofalse &&
                   {1'b0, nxt.cutoff} == {1'b0, nxt.true_count} + 9'd1) begin
         status = ST_CONSISTENT;
         action = ACT_FORCE_FALSE;
      end
   end

   // Only a propagate item reports
   always_comb begin
      rsp = '0;
      if (prop) begin
         rsp.status       = status;
         rsp.action       = action;
         rsp.assign_level = (action != ACT_NONE) ? req.decision_level : 16'd0;
      end
   end

endmodule

@@ rtl/cardinality_constraint_propagator.sv @@
// Top level of the counter-based at-least-K constraint propagator.
//
// Input: req_payload is transferred at a rising edge with start high and busy
// low. func selects load entry, propagate event or reverse event; entry_index
// addresses one of ENTRIES table entries.
// Output: one result per item, shown on rsp_payload for one cycle while
// rsp_strobe is high. The receiver cannot hold results off.
// Timing: the accepting edge issues the table read; the next cycle updates the
// counts, classifies the entry and writes it back; the result appears in the
// cycle after that. A new item is taken only once the last one is written
// back, as the memory read is followed by the write-back.
// busy is high in the cycle between accept and write-back.
// Reset: clears the sequencer and the strobe. The table is not cleared; an
// entry must be loaded before it is propagated or reversed.
// Items with an index at or beyond ENTRIES, and unused func codes, leave the
// table alone and report all-zero results.
module cardinality_constraint_propagator #(
   parameter int ENTRIES = ccp_pkg::CCP_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ccp_pkg::ccp_req_type req_payload,
   output logic                 rsp_strobe,
   output ccp_pkg::ccp_rsp_type rsp_payload
);
   import ccp_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [16:0] ENTRIES_W = 17'(ENTRIES);

   ccp_state_type state_ff, state_in;
   ccp_req_type   req_ff;
   logic          in_range_ff;
   logic          accept;
   logic          strobe_ff, strobe_in;
   ccp_rsp_type   rsp_ff;
   ccp_entry_type rd_entry, wr_entry;
   ccp_rsp_type   eval_rsp;
   logic          upd_en, wr_en;

   assign accept = start && (state_ff == CCP_IDLE);
   assign busy   = (state_ff != CCP_IDLE);

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CCP_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Next state: read cycle, then modify and write back
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         CCP_IDLE: begin
            if (accept) begin
               state_in = CCP_RMW;
            end
         end
         CCP_RMW: begin
            state_in  = CCP_IDLE;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = CCP_IDLE;
         end
      endcase
   end

   // Hold the request for the write-back cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_payload;
         in_range_ff <= (17'(req_payload.entry_index) < ENTRIES_W);
      end
   end

   ccp_table #(
      .ENTRIES(ENTRIES),
      .AW     (AW)
   ) u_table (
      .clock  (clock),
      .rd_en  (accept),
      .rd_addr(AW'(req_payload.entry_index)),
      .rd_data(rd_entry),
      .wr_en  (wr_en),
      .wr_addr(AW'(req_ff.entry_index)),
      .wr_data(wr_entry)
   );

   ccp_eval u_eval (
      .req   (req_ff),
      .cur   (rd_entry),
      .nxt   (wr_entry),
      .upd_en(upd_en),
      .rsp   (eval_rsp)
   );

   assign wr_en = (state_ff == CCP_RMW) && in_range_ff && upd_en;

   // Register the result; drop it to zero for an index out of range
   always_ff @(posedge clock) begin
      if (state_ff == CCP_RMW) begin
         rsp_ff <= in_range_ff ? eval_rsp : '0;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/ccp_chk.sv @@
// Port-level checker of the constraint propagator, bound to the top level.
`include "cardinality_constraint_propagator_macros.svh"

module ccp_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input ccp_pkg::ccp_rsp_type rsp_payload
);
   import ccp_pkg::*;

   logic act_seen, no_act_seen, status_ok, level_zero;

   // Classify the result on the ports
   assign act_seen    = rsp_strobe && (rsp_payload.action != ACT_NONE);
   assign no_act_seen = rsp_strobe && (rsp_payload.action == ACT_NONE);
   assign status_ok   = (rsp_payload.status == ST_CONSISTENT);
   assign level_zero  = (rsp_payload.assign_level == 16'd0);

   // A transfer in makes the block busy in the next cycle
   `CCP_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy missing after transfer")

   // Every transfer in gives a result after its write-back cycle
   `CCP_ASSERT(a_accept_rsp, (start && !busy) |-> ##2 rsp_strobe, "result missing")

   // A result follows a busy cycle
   `CCP_ASSERT(a_rsp_after_busy, rsp_strobe |-> $past(busy), "result without work")

   // Requested assignments come only with a consistent status; a result without one has a zero level
   `CCP_ASSERT(a_action_consistent, act_seen |-> status_ok, "action with bad status")
   `CCP_ASSERT(a_level_zero, no_act_seen |-> level_zero, "level without action")

endmodule

bind cardinality_constraint_propagator ccp_chk u_ccp_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_payload(rsp_payload)
);

@@ test/testbench.sv @@
// Testbench for the cardinality constraint propagator: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
   import ccp_pkg::*;

   // Codes the package leaves unnamed
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam logic [1:0] EVT_OUTPUT = 2'd2;
   localparam logic [1:0] EVT_SPARE  = 2'd3;
   localparam logic [1:0] OUT_UNDEF  = 2'd0;
   localparam logic [1:0] OUT_SPARE  = 2'd3;

   localparam ccp_rsp_type ZERO_RSP = '0;
   localparam int RANDOM_ITEMS = 600;
   localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;

   typedef struct {
      ccp_req_type item;
      bit          typed;
      ccp_rsp_type rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ccp_req_type req_payload = '0;
   logic        rsp_strobe;
   ccp_rsp_type rsp_payload;

   // Shadow copy of the constraint table
   logic [7:0] cutoff_mem    [CCP_ENTRIES];
   logic [7:0] true_mem      [CCP_ENTRIES];
   logic [7:0] undef_mem     [CCP_ENTRIES];
   logic       no_output_mem [CCP_ENTRIES];

   // Entries that hold a loaded constraint, most recent last
   bit loaded_flag [CCP_ENTRIES];
   int loaded_q [$];

   stim_row_type directed_q [$];
   ccp_rsp_type  outcome_q [$];
   int           mismatch_count = 0;

   cardinality_constraint_propagator u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("%0t timeout, %0d results outstanding", $time, outcome_q.size());
      $display("testbench NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Append one row to the directed table
   task automatic queue_row(input stim_row_type row);
      directed_q = {directed_q, row};
   endtask

   // Update the shadow entry and classify it the way the block must
   function automatic ccp_rsp_type constraint_outcome(input ccp_req_type item);
      ccp_rsp_type res;
      int unsigned e;
      int unsigned t;
      int unsigned u;
      int unsigned c;
      bit          holds;
      bit          out_false;
      res = '0;
      e = 32'(item.entry_index);
      case (item.func)
         FUNC_LOAD: begin
            cutoff_mem[e]    = item.load_cutoff;
            true_mem[e]      = item.load_true_count;
            undef_mem[e]     = item.load_undef_count;
            no_output_mem[e] = item.load_no_output;
         end
         FUNC_PROPAGATE: begin
            if (item.event_kind == EVT_TRUE_COUNT) begin
               true_mem[e]  = (true_mem[e] == 8'hFF) ? 8'hFF : true_mem[e] + 8'd1;
               undef_mem[e] = (undef_mem[e] == 8'h00) ? 8'h00 : undef_mem[e] - 8'd1;
            end else if (item.event_kind == EVT_NON_COUNT) begin
               undef_mem[e] = (undef_mem[e] == 8'h00) ? 8'h00 : undef_mem[e] - 8'd1;
            end
            t = 32'(true_mem[e]);
            u = 32'(undef_mem[e]);
            c = 32'(cutoff_mem[e]);
            holds = no_output_mem[e] || item.out_value == OUT_TRUE;
            out_false = !no_output_mem[e] && item.out_value == OUT_FALSE;
            if (t + u < c) begin
               if (holds) begin
                  res.status = ST_CONFLICT;
               end else begin
                  res.status = ST_CONSISTENT;
                  if (!out_false) res.action = ACT_OUT_FALSE;
               end
            end else if (t >= c) begin
               if (holds) begin
                  res.status = ST_CONSISTENT;
               end else if (out_false) begin
                  res.status = ST_CONFLICT;
               end else begin
                  res.status = ST_CONSISTENT;
                  res.action = ACT_OUT_TRUE;
               end
            end else if (holds && c - t == u) begin
               res.status = ST_CONSISTENT;
               res.action = ACT_FORCE_TRUE;
            end else if (out_false && c == t + 1) begin
               res.status = ST_CONSISTENT;
               res.action = ACT_FORCE_FALSE;
            end else begin
               res.status = ST_UNDECIDED;
            end
            if (res.action != ACT_NONE) res.assign_level = item.decision_level;
         end
         FUNC_REVERSE: begin
            if (item.event_kind == EVT_TRUE_COUNT) begin
               true_mem[e]  = (true_mem[e] == 8'h00) ? 8'h00 : true_mem[e] - 8'd1;
               undef_mem[e] = (undef_mem[e] == 8'hFF) ? 8'hFF : undef_mem[e] + 8'd1;
            end else if (item.event_kind == EVT_NON_COUNT) begin
               undef_mem[e] = (undef_mem[e] == 8'hFF) ? 8'hFF : undef_mem[e] + 8'd1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic stim_row_type make_row(
      input logic [1:0]  func,
      input int          idx,
      input logic [1:0]  kind,
      input logic [1:0]  outv,
      input logic [15:0] lvl,
      input logic [7:0]  cut,
      input logic [7:0]  tc,
      input logic [7:0]  uc,
      input logic        no_out,
      input bit          typed,
      input ccp_rsp_type rsp
   );
      stim_row_type row;
      row.item.func             = func;
      row.item.entry_index      = 10'(idx);
      row.item.event_kind       = kind;
      row.item.out_value        = outv;
      row.item.decision_level   = lvl;
      row.item.load_cutoff      = cut;
      row.item.load_true_count  = tc;
      row.item.load_undef_count = uc;
      row.item.load_no_output   = no_out;
      row.typed                 = typed;
      row.rsp                   = rsp;
      return row;
   endfunction

   // Present one item, hold it until the block takes it, then queue its outcome
   task automatic issue_request(
      input ccp_req_type item,
      input bit          typed,
      input ccp_rsp_type typed_rsp,
      input int          idle_pct
   );
      ccp_rsp_type predicted;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = constraint_outcome(item);
      outcome_q = {outcome_q, typed ? typed_rsp : predicted};
      if (item.func == FUNC_LOAD && !loaded_flag[item.entry_index]) begin
         loaded_flag[item.entry_index] = 1'b1;
         loaded_q = {loaded_q, int'(item.entry_index)};
      end
   endtask

   // Compare each transfer on the result side with the oldest outcome
   always @(posedge clock) begin : check_results
      ccp_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outcome_q.size() == 0) begin
            report_mismatch($sformatf("result %p with nothing outstanding", rsp_payload));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_payload.status, want.status));
            if (rsp_payload.action !== want.action)
               report_mismatch($sformatf("action %0d, want %0d",
                                         rsp_payload.action, want.action));
            if (rsp_payload.assign_level !== want.assign_level)
               report_mismatch($sformatf("assign_level %h, want %h",
                                         rsp_payload.assign_level, want.assign_level));
         end
      end
   end

   initial begin
      ccp_req_type  item;
      int           idle_pct;
      int           pick;
      int           window;
      int           phase_idle [4];

      phase_idle = '{0, 67, 15, 0};

      // Extremes, each event kind and output value, saturation, spare codes
      queue_row(make_row(FUNC_LOAD, 0, EVT_TRUE_COUNT, OUT_UNDEF, 16'h0000,
                         3, 0, 5, 0, 1, ZERO_RSP));
      queue_row(make_row(FUNC_LOAD, 1023, EVT_SPARE, OUT_SPARE, 16'hFFFF,
                         255, 255, 255, 1, 1, ZERO_RSP));
      queue_row(make_row(FUNC_LOAD, 512, EVT_OUTPUT, OUT_TRUE, 16'h5555,
                         0, 0, 0, 0, 1, ZERO_RSP));
      queue_row(make_row(FUNC_LOAD, 341, EVT_NON_COUNT, OUT_FALSE, 16'hAAAA,
                         4, 1, 2, 0, 1, ZERO_RSP));
      queue_row(make_row(FUNC_LOAD, 682, EVT_TRUE_COUNT, OUT_UNDEF, 16'h0F0F,
                         2, 0, 2, 1, 1, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 0, EVT_TRUE_COUNT, OUT_UNDEF, 16'hFFFF,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 0, EVT_TRUE_COUNT, OUT_FALSE, 16'h1234,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 0, EVT_TRUE_COUNT, OUT_TRUE, 16'h0000,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 0, EVT_OUTPUT, OUT_UNDEF, 16'hABCD,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 0, EVT_OUTPUT, OUT_FALSE, 16'h8001,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 341, EVT_OUTPUT, OUT_UNDEF, 16'h7FFE,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 341, EVT_OUTPUT, OUT_TRUE, 16'h0001,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 341, EVT_SPARE, OUT_FALSE, 16'h4321,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 341, EVT_OUTPUT, OUT_SPARE, 16'h00F0,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 682, EVT_OUTPUT, OUT_TRUE, 16'h00FF,
                         0, 0, 0, 0, 1,
                         ccp_rsp_type'{ST_CONSISTENT, ACT_FORCE_TRUE, 16'h00FF}));
      queue_row(make_row(FUNC_PROPAGATE, 682, EVT_NON_COUNT, OUT_UNDEF, 16'h1111,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_REVERSE, 682, EVT_NON_COUNT, OUT_UNDEF, 16'h2222,
                         0, 0, 0, 0, 1, ZERO_RSP));
      queue_row(make_row(FUNC_REVERSE, 682, EVT_TRUE_COUNT, OUT_TRUE, 16'h3333,
                         0, 0, 0, 0, 1, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 1023, EVT_TRUE_COUNT, OUT_UNDEF, 16'hFFFF,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 1023, EVT_NON_COUNT, OUT_FALSE, 16'hFF00,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_REVERSE, 1023, EVT_TRUE_COUNT, OUT_UNDEF, 16'h0000,
                         0, 0, 0, 0, 1, ZERO_RSP));
      queue_row(make_row(FUNC_REVERSE, 1023, EVT_NON_COUNT, OUT_UNDEF, 16'h0000,
                         0, 0, 0, 0, 1, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 512, EVT_TRUE_COUNT, OUT_UNDEF, 16'h0F0F,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_PROPAGATE, 512, EVT_NON_COUNT, OUT_FALSE, 16'hF0F0,
                         0, 0, 0, 0, 0, ZERO_RSP));
      queue_row(make_row(FUNC_REVERSE, 512, EVT_TRUE_COUNT, OUT_SPARE, 16'h6666,
                         0, 0, 0, 0, 1, ZERO_RSP));
      queue_row(make_row(FUNC_SPARE, 0, EVT_TRUE_COUNT, OUT_UNDEF, 16'hFFFF,
                         9, 9, 9, 1, 1, ZERO_RSP));

      // Hold reset, then release it once
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_q[i])
         issue_request(directed_q[i].item, directed_q[i].typed, directed_q[i].rsp, 0);

      // Random traffic, mostly event sequences on recently loaded entries
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_pct = phase_idle[n / PHASE_ITEMS];
         item.entry_index      = 10'($urandom_range(CCP_ENTRIES - 1));
         item.event_kind       = 2'($urandom_range(3));
         item.out_value        = 2'($urandom_range(3));
         item.decision_level   = 16'($urandom);
         item.load_cutoff      = 8'($urandom);
         item.load_true_count  = 8'($urandom);
         item.load_undef_count = 8'($urandom);
         item.load_no_output   = 1'($urandom_range(1));
         window = (loaded_q.size() < 8) ? loaded_q.size() : 8;
         pick = $urandom_range(99);
         if (pick < 15) begin
            item.func = FUNC_LOAD;
            if ($urandom_range(1) == 0)
               item.entry_index = 10'(loaded_q[$urandom_range(loaded_q.size() - 1)]);
            // Small counts keep the entry near its decision points
            if ($urandom_range(4) != 0) begin
               item.load_cutoff      = 8'($urandom_range(8));
               item.load_true_count  = 8'($urandom_range(4));
               item.load_undef_count = 8'($urandom_range(8));
            end
         end else begin
            if (pick < 65)
               item.func = FUNC_PROPAGATE;
            else if (pick < 95)
               item.func = FUNC_REVERSE;
            else
               item.func = FUNC_SPARE;
            if ($urandom_range(4) != 0)
               item.entry_index =
                  10'(loaded_q[loaded_q.size() - 1 - $urandom_range(window - 1)]);
            else
               item.entry_index = 10'(loaded_q[$urandom_range(loaded_q.size() - 1)]);
         end
         issue_request(item, 1'b0, ZERO_RSP, idle_pct);
      end
      start <= 1'b0;

      // Drain, then leave room for a stray result
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
